FILE: design/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies.
package stq_pkg;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    CMD_ADD_ID = 2'd0, CMD_ADD_ANON = 2'd1, CMD_CANCEL = 2'd2, CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_ADDED = 3'd0, K_REJ_PAST = 3'd1, K_REJ_FULL = 3'd2, K_CANCELLED = 3'd3,
    K_NOT_FOUND = 3'd4, K_FIRED = 3'd5, K_NONE = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_CANCEL2, ST_TICK, ST_OUT
  } state_t;

  // queue operation handed to every cell of one chain
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0, OP_INSERT = 2'd1, OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        clock_sel;
    logic [63:0] deadline_ticks;
    logic [31:0] cancel_id;
    logic [63:0] now_mono;
    logic [63:0] now_real;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_ident;
    logic        clock_of;
    logic [63:0] remaining_ticks;
    logic [63:0] next_due_mono;
    logic [63:0] next_due_real;
    logic        last;
  } out_beat_t;
endpackage

FILE: design/stq_cell.sv
// One queue slot: expiry and id, with compare flags towards its neighbours and the chain.
// Depends on stq_pkg.
module stq_cell #(
  parameter int ID_BITS = 32
) (
  input  logic               clk,
  input  stq_pkg::op_t       op,
  input  logic [63:0]        key,
  input  logic [ID_BITS-1:0] key_id,
  input  logic [ID_BITS-1:0] new_id,
  input  logic               live,
  input  logic               left_later,   // left neighbour is later than key
  input  logic [63:0]        left_exp,
  input  logic [ID_BITS-1:0] left_ident,
  input  logic               left_hit,     // match at or left of neighbour
  input  logic [63:0]        right_exp,
  input  logic [ID_BITS-1:0] right_ident,
  output logic               later,        // live and expiry > key
  output logic               hit_upto,     // first id match at or before here
  output logic [63:0]        exp_r,
  output logic [ID_BITS-1:0] ident_r
);
  import stq_pkg::*;
  logic hit;
  assign later    = live && (exp_r > key);
  assign hit      = live && (ident_r == key_id);
  assign hit_upto = hit || left_hit;

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (left_later) begin
          exp_r   <= left_exp;
          ident_r <= left_ident;
        end else if (later || !live) begin
          exp_r   <= key;
          ident_r <= new_id;
        end
      end
      OP_REMOVE: begin
        if (hit_upto) begin
          exp_r   <= right_exp;
          ident_r <= right_ident;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: design/stq_chain.sv
// A row of stq_cell slots forming one sorted queue with its live count.
// Depends on stq_pkg and stq_cell.
module stq_chain #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 32,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::op_t       op,
  input  logic [63:0]        key,
  input  logic [ID_BITS-1:0] key_id,
  input  logic [ID_BITS-1:0] new_id,
  output logic               found,
  output logic [63:0]        found_exp,
  output logic [63:0]        head_exp,
  output logic [ID_BITS-1:0] head_ident,
  output logic [CW-1:0]      count_r
);
  import stq_pkg::*;
  logic [QUEUE_DEPTH-1:0] later, hit_upto, live;
  logic [63:0]        exps [QUEUE_DEPTH];
  logic [ID_BITS-1:0] ids  [QUEUE_DEPTH];
  logic [63:0] sel_exp;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign live[g] = CW'(g) < count_r;
      stq_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk(clk), .op(op), .key(key), .key_id(key_id), .new_id(new_id),
        .live(live[g]),
        .left_later((g == 0) ? 1'b0 : later[(g == 0) ? 0 : g-1]),
        .left_exp(exps[(g == 0) ? 0 : g-1]),
        .left_ident(ids[(g == 0) ? 0 : g-1]),
        .left_hit((g == 0) ? 1'b0 : hit_upto[(g == 0) ? 0 : g-1]),
        .right_exp(exps[(g == QUEUE_DEPTH-1) ? g : g+1]),
        .right_ident(ids[(g == QUEUE_DEPTH-1) ? g : g+1]),
        .later(later[g]), .hit_upto(hit_upto[g]),
        .exp_r(exps[g]), .ident_r(ids[g]));
    end
  endgenerate

  // expiry of first match, AND-OR over one-hot first-hit vector
  always_comb begin
    sel_exp = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (hit_upto[i] && (i == 0 || !hit_upto[(i == 0) ? 0 : i-1]))
        sel_exp = sel_exp | exps[i];
  end
  assign found      = hit_upto[QUEUE_DEPTH-1];
  assign found_exp  = sel_exp;
  assign head_exp   = (count_r != '0) ? exps[0] : 64'd0;
  assign head_ident = ids[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (op)
        OP_INSERT: count_r <= count_r + CW'(1);
        OP_REMOVE: count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end
endmodule

FILE: design/sorted_timer_queue.sv
// Sorted deadline timer queue, top level: controller plus two cell chains.
// Depends on stq_pkg, stq_chain.
//
// Usage: one command beat enters on in_* (valid/stall). Each command yields
// one result beat on out_*, except a tick, which yields one beat per fired
// entry (up to 32, monotonic queue first), the final one with last set, or
// a single none beat if nothing is due. Steps: an add goes from exec to
// output; a cancel searches the monotonic queue in exec and, on a miss, the
// realtime queue in a second state, then outputs; a tick pops one due head
// and outputs its beat, once per result beat. One command is worked on at a
// time; the next is taken the cycle after the last result beat has left.
// The controller hands queue operations to the shift-register cell chains.
// Each queue is a row of cells that shift right on insert (the new entry
// lands before the first strictly later one) and left on remove; a search
// for cancel and the sort compare happen in all cells at once.
// Reset (rst_n low, synchronous) empties both queues and clears the id
// counter; slot contents are not cleared and never read until written.
// A stall on out_ holds the result beat; in_stall stays high meanwhile.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stq_pkg::out_beat_t out_data
);
  import stq_pkg::*;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = $clog2(MAX_RESULTS + 1);

  state_t state_r, state_nxt;
  in_beat_t cmd_r;
  out_beat_t res_r, res_nxt;
  logic [ID_BITS-1:0] idc_r, idc_nxt, idc_inc;
  logic [FW-1:0] fired_r, fired_nxt;
  logic in_acc;

  op_t op_m, op_q;
  logic [63:0] key_m, key_q;
  logic [ID_BITS-1:0] kid, nid;
  logic fnd_m, fnd_q;
  logic [63:0] fexp_m, fexp_q, hexp_m, hexp_q;
  logic [ID_BITS-1:0] hid_m, hid_q;
  logic [CW-1:0] cnt_m, cnt_q;
  logic out_pend_r, out_pend_nxt;

  stq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_mono (
    .clk(clk), .rst_n(rst_n), .op(op_m), .key(key_m), .key_id(kid),
    .new_id(nid), .found(fnd_m), .found_exp(fexp_m), .head_exp(hexp_m),
    .head_ident(hid_m), .count_r(cnt_m));
  stq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_real (
    .clk(clk), .rst_n(rst_n), .op(op_q), .key(key_q), .key_id(kid),
    .new_id(nid), .found(fnd_q), .found_exp(fexp_q), .head_exp(hexp_q),
    .head_ident(hid_q), .count_r(cnt_q));

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_pend_r;
  assign out_data  = res_r;

  // search id: cancel id resized to the id width; on a tick the head id of
  // the queue being popped, so the first match is always slot 0
  always_comb begin
    if (state_r == ST_TICK)
      kid = (cnt_m != '0 && cmd_r.now_mono > hexp_m) ? hid_m : hid_q;
    else
      kid = ID_BITS'(cmd_r.cancel_id);
  end

  always_comb begin
    idc_inc = idc_r + ID_BITS'(1);
    if (idc_inc == '0) idc_inc = ID_BITS'(1);
  end

  always_comb begin
    logic [63:0] now_c;
    logic [CW-1:0] cnt_c;
    state_nxt    = state_r;
    res_nxt      = res_r;
    idc_nxt      = idc_r;
    fired_nxt    = fired_r;
    out_pend_nxt = out_pend_r;
    op_m = OP_HOLD; op_q = OP_HOLD;
    key_m = cmd_r.deadline_ticks; key_q = cmd_r.deadline_ticks;
    nid = '0;
    now_c = cmd_r.clock_sel ? cmd_r.now_real : cmd_r.now_mono;
    cnt_c = cmd_r.clock_sel ? cnt_q : cnt_m;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
        fired_nxt = '0;
      end
      ST_EXEC: begin
        res_nxt = '0;
        res_nxt.last = 1'b1;
        case (cmd_r.cmd)
          CMD_ADD_ID, CMD_ADD_ANON: begin
            res_nxt.clock_of = cmd_r.clock_sel;
            state_nxt = ST_OUT;
            if (cmd_r.deadline_ticks <= now_c) begin
              res_nxt.kind = K_REJ_PAST;
            end else if (cnt_c == CW'(QUEUE_DEPTH)) begin
              res_nxt.kind = K_REJ_FULL;
            end else begin
              res_nxt.kind = K_ADDED;
              if (cmd_r.cmd == CMD_ADD_ID) begin
                nid = idc_inc;
                idc_nxt = idc_inc;
              end
              res_nxt.timer_ident = 32'(nid);
              if (cmd_r.clock_sel) op_q = OP_INSERT;
              else op_m = OP_INSERT;
            end
          end
          CMD_CANCEL: begin
            res_nxt.timer_ident = cmd_r.cancel_id;
            if (fnd_m) begin
              op_m = OP_REMOVE;
              key_m = '0;
              res_nxt.kind = K_CANCELLED;
              res_nxt.remaining_ticks = (fexp_m > cmd_r.now_mono) ?
                                        fexp_m - cmd_r.now_mono : 64'd0;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_CANCEL2;
            end
          end
          default: state_nxt = ST_TICK;
        endcase
      end
      ST_CANCEL2: begin
        state_nxt = ST_OUT;
        if (fnd_q) begin
          op_q = OP_REMOVE;
          res_nxt.kind = K_CANCELLED;
          res_nxt.clock_of = 1'b1;
          res_nxt.remaining_ticks = (fexp_q > cmd_r.now_real) ?
                                    fexp_q - cmd_r.now_real : 64'd0;
        end else begin
          res_nxt.kind = K_NOT_FOUND;
        end
      end
      ST_TICK: begin
        // pop one due head per visit, monotonic queue first
        res_nxt = '0;
        state_nxt = ST_OUT;
        if (fired_r != FW'(MAX_RESULTS) && cnt_m != '0 && cmd_r.now_mono > hexp_m) begin
          op_m = OP_REMOVE; key_m = '0;
          res_nxt.kind = K_FIRED;
          res_nxt.timer_ident = 32'(hid_m);
          fired_nxt = fired_r + FW'(1);
        end else if (fired_r != FW'(MAX_RESULTS) && cnt_q != '0 &&
                     cmd_r.now_real > hexp_q) begin
          op_q = OP_REMOVE;
          res_nxt.kind = K_FIRED;
          res_nxt.clock_of = 1'b1;
          res_nxt.timer_ident = 32'(hid_q);
          fired_nxt = fired_r + FW'(1);
        end else if (fired_r == '0) begin
          res_nxt.kind = K_NONE;
          res_nxt.last = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        // heads are sampled once the queue shift has landed
        if (!out_pend_r) begin
          res_nxt.next_due_mono = hexp_m;
          res_nxt.next_due_real = hexp_q;
          out_pend_nxt = 1'b1;
          if (cmd_r.cmd == CMD_TICK && res_r.kind == K_FIRED) begin
            // peek: is this the final firing?
            res_nxt.last = (fired_r == FW'(MAX_RESULTS)) ||
              !((cnt_m != '0 && cmd_r.now_mono > hexp_m) ||
                (cnt_q != '0 && cmd_r.now_real > hexp_q));
          end
        end else if (!out_stall) begin
          out_pend_nxt = 1'b0;
          state_nxt = res_r.last ? ST_IDLE : ST_TICK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idc_r      <= '0;
      fired_r    <= '0;
      out_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idc_r      <= idc_nxt;
      fired_r    <= fired_nxt;
      out_pend_r <= out_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) cmd_r <= in_data;
  end
endmodule

FILE: bench/tb_sorted_timer_queue.sv
// Testbench for sorted_timer_queue: directed and random timer commands,
// results checked beat by beat against a behavioural queue model.
// Depends on stq_pkg and the sorted_timer_queue RTL.
`timescale 1ns / 1ps
module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int DEPTH = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  sorted_timer_queue #(.QUEUE_DEPTH(DEPTH), .ID_BITS(32)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state: two sorted queues plus the id counter
  logic [63:0] mono_due_q[$];
  logic [31:0] mono_id_q[$];
  logic [63:0] real_due_q[$];
  logic [31:0] real_id_q[$];
  logic [31:0] last_id;
  out_beat_t   pending_results[$];
  int          fails = 0;
  int          hold_off = 0;    // cycles of forced receiver stall
  bit          stall_pattern = 1'b1;
  logic [31:0] seen_ids[$];     // ids handed out, for cancel targets

  function automatic out_beat_t mk_result(kind_t k, logic [31:0] id, logic q,
                                          logic [63:0] rem, logic is_last);
    out_beat_t r;
    r.kind = k;
    r.timer_ident = id;
    r.clock_of = q;
    r.remaining_ticks = rem;
    r.next_due_mono = mono_due_q.size() ? mono_due_q[0] : 64'd0;
    r.next_due_real = real_due_q.size() ? real_due_q[0] : 64'd0;
    r.last = is_last;
    return r;
  endfunction

  // Works out the result beats of one accepted command and queues them
  task automatic predict_timer_cmd(input in_beat_t b);
    int          pos;
    int          fired;
    logic        q;
    logic [63:0] now;
    logic [63:0] due;
    logic [31:0] id;
    logic [63:0] rem;
    pos = 0;
    fired = 0;
    case (cmd_t'(b.cmd))
      CMD_ADD_ID, CMD_ADD_ANON: begin
        q = b.clock_sel;
        now = q ? b.now_real : b.now_mono;
        if (b.deadline_ticks <= now)
          pending_results.push_back(mk_result(K_REJ_PAST, 32'd0, q, 64'd0, 1'b1));
        else if ((q ? real_due_q.size() : mono_due_q.size()) >= DEPTH)
          pending_results.push_back(mk_result(K_REJ_FULL, 32'd0, q, 64'd0, 1'b1));
        else begin
          id = 32'd0;
          if (b.cmd == CMD_ADD_ID) begin
            last_id = last_id + 32'd1;
            if (last_id == 32'd0) last_id = 32'd1;
            id = last_id;
            seen_ids.push_back(id);
          end
          // entry goes before the first strictly later expiry
          if (q) begin
            while (pos < real_due_q.size() && real_due_q[pos] <= b.deadline_ticks) pos++;
            real_due_q.insert(pos, b.deadline_ticks);
            real_id_q.insert(pos, id);
          end else begin
            while (pos < mono_due_q.size() && mono_due_q[pos] <= b.deadline_ticks) pos++;
            mono_due_q.insert(pos, b.deadline_ticks);
            mono_id_q.insert(pos, id);
          end
          pending_results.push_back(mk_result(K_ADDED, id, q, 64'd0, 1'b1));
        end
      end
      CMD_CANCEL: begin
        q = 1'b0;
        pos = -1;
        foreach (mono_id_q[i]) if (pos < 0 && mono_id_q[i] == b.cancel_id) pos = i;
        if (pos < 0) begin
          q = 1'b1;
          foreach (real_id_q[i]) if (pos < 0 && real_id_q[i] == b.cancel_id) pos = i;
        end
        if (pos < 0)
          pending_results.push_back(mk_result(K_NOT_FOUND, b.cancel_id, 1'b0, 64'd0, 1'b1));
        else begin
          if (q) begin
            due = real_due_q[pos];
            now = b.now_real;
            real_due_q.delete(pos);
            real_id_q.delete(pos);
          end else begin
            due = mono_due_q[pos];
            now = b.now_mono;
            mono_due_q.delete(pos);
            mono_id_q.delete(pos);
          end
          rem = (due > now) ? due - now : 64'd0;
          pending_results.push_back(mk_result(K_CANCELLED, b.cancel_id, q, rem, 1'b1));
        end
      end
      default: begin
        // monotonic heads first, then realtime; capped per tick
        while (fired < MAX_RESULTS && mono_due_q.size() && b.now_mono > mono_due_q[0]) begin
          id = mono_id_q.pop_front();
          void'(mono_due_q.pop_front());
          pending_results.push_back(mk_result(K_FIRED, id, 1'b0, 64'd0, 1'b0));
          fired++;
        end
        while (fired < MAX_RESULTS && real_due_q.size() && b.now_real > real_due_q[0]) begin
          id = real_id_q.pop_front();
          void'(real_due_q.pop_front());
          pending_results.push_back(mk_result(K_FIRED, id, 1'b1, 64'd0, 1'b0));
          fired++;
        end
        if (fired == 0)
          pending_results.push_back(mk_result(K_NONE, 32'd0, 1'b0, 64'd0, 1'b1));
        else
          pending_results[pending_results.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // Sender: drives one beat and waits for its handshake. Gaps between
  // bursts are random; within a burst valid stays high across beats.
  int burst_left = 0;
  task automatic send_cmd(input in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_cmd(b);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic in_beat_t mk_cmd(cmd_t c, logic q, logic [63:0] due,
                                      logic [31:0] cid, logic [63:0] nm,
                                      logic [63:0] nr);
    in_beat_t b;
    b.cmd = c;
    b.clock_sel = q;
    b.deadline_ticks = due;
    b.cancel_id = cid;
    b.now_mono = nm;
    b.now_real = nr;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver stall pattern, plus the long hold-off when asked for
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (!stall_pattern)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    out_beat_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d id %0h",
               out_data.kind, out_data.timer_ident);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_data.kind); fails++;
        end
        if (out_data.timer_ident !== exp_r.timer_ident) begin
          $error("timer_ident: expected %0h, got %0h",
                 exp_r.timer_ident, out_data.timer_ident); fails++;
        end
        if (out_data.clock_of !== exp_r.clock_of) begin
          $error("clock_of: expected %0d, got %0d", exp_r.clock_of, out_data.clock_of);
          fails++;
        end
        if (out_data.remaining_ticks !== exp_r.remaining_ticks) begin
          $error("remaining_ticks: expected %0h, got %0h",
                 exp_r.remaining_ticks, out_data.remaining_ticks); fails++;
        end
        if (out_data.next_due_mono !== exp_r.next_due_mono) begin
          $error("next_due_mono: expected %0h, got %0h",
                 exp_r.next_due_mono, out_data.next_due_mono); fails++;
        end
        if (out_data.next_due_real !== exp_r.next_due_real) begin
          $error("next_due_real: expected %0h, got %0h",
                 exp_r.next_due_real, out_data.next_due_real); fails++;
        end
        if (out_data.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_data.last); fails++;
        end
      end
    end
  end

  // Extremes of every field, each command and each corner named in the spec
  task automatic test_directed();
    logic [63:0] max64;
    max64 = '1;
    send_cmd(mk_cmd(CMD_TICK, 1'b0, 64'd0, 32'd0, 64'd0, 64'd0));      // nothing due
    send_cmd(mk_cmd(CMD_ADD_ID, 1'b0, 64'd5, 32'd0, 64'd5, 64'd0));    // past: equal
    send_cmd(mk_cmd(CMD_ADD_ID, 1'b1, 64'd0, 32'd0, 64'd0, max64));    // past
    send_cmd(mk_cmd(CMD_ADD_ID, 1'b0, max64, 32'hffff_ffff, 64'd0, max64));
    send_cmd(mk_cmd(CMD_ADD_ID, 1'b1, max64, 32'd0, max64, 64'd0));
    send_cmd(mk_cmd(CMD_ADD_ANON, 1'b0, 64'd100, 32'd0, 64'd1, 64'd0));
    send_cmd(mk_cmd(CMD_ADD_ANON, 1'b1, 64'd100, 32'd0, 64'd0, 64'd1));
    send_cmd(mk_cmd(CMD_ADD_ID, 1'b0, 64'd100, 32'd0, 64'd1, 64'd0));  // tie: goes after
    send_cmd(mk_cmd(CMD_CANCEL, 1'b0, 64'd0, 32'd0, 64'd10, 64'd10));  // id 0, mono anon
    send_cmd(mk_cmd(CMD_CANCEL, 1'b1, 64'd0, 32'd0, 64'd200, 64'd200)); // id 0, real, past
    send_cmd(mk_cmd(CMD_CANCEL, 1'b0, 64'd0, 32'd2, max64, max64));    // realtime hit
    send_cmd(mk_cmd(CMD_CANCEL, 1'b0, 64'd0, 32'hdead_beef, 64'd0, 64'd0)); // miss
    send_cmd(mk_cmd(CMD_TICK, 1'b0, 64'd0, 32'd0, 64'd100, 64'd0));    // equal: not due
    send_cmd(mk_cmd(CMD_TICK, 1'b0, 64'd0, 32'd0, max64, max64));
    // fill monotonic queue, then overflow it
    for (int i = 0; i < DEPTH + 1; i++)
      send_cmd(mk_cmd(CMD_ADD_ID, 1'b0, 64'd50 + i, 32'd0, 64'd0, 64'd0));
    send_cmd(mk_cmd(CMD_TICK, 1'b1, max64, 32'd0, max64, max64));
  endtask

  // Random mix, biased towards adds and cancels of ids already handed out
  task automatic test_random(input int n);
    in_beat_t b;
    int sel;
    logic [63:0] base;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      base = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 4000));
      b = mk_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                 base + $urandom_range(0, 2000), $urandom(), base,
                 base + $urandom_range(0, 50));
      if (sel < 5)
        b.cmd = ($urandom_range(0, 3) == 0) ? CMD_ADD_ANON : CMD_ADD_ID;
      else if (sel < 7) begin
        b.cmd = CMD_CANCEL;
        if (seen_ids.size() && $urandom_range(0, 3) != 0)
          b.cancel_id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
          b.cancel_id = 32'd0;
      end
      send_cmd(b);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 12; i++)
      send_cmd(mk_cmd(CMD_ADD_ID, i[0], 64'd900 + i, 32'd0, 64'd0, 64'd0));
    send_cmd(mk_cmd(CMD_TICK, 1'b0, 64'd0, 32'd0, '1, '1));
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    idle_sender();
    while (pending_results.size() && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  initial begin
    last_id = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    stall_pattern = 1'b0;
    test_random(60);
    stall_pattern = 1'b1;
    test_random(55);
    wait_drain();
    if (fails == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
design/stq_pkg.sv
design/stq_cell.sv
design/stq_chain.sv
design/sorted_timer_queue.sv
bench/tb_sorted_timer_queue.sv
